// File: rtl/srl_pkg.sv
// ----------------------------------------------------------------------------
// srl_pkg : shared definitions for the S-record line loader
// Parameter defaults, character codes, result kinds, controller states and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srl_pkg;

    // Parameter defaults
    localparam int LINE_LIMIT_DEF   = 59;
    localparam int BUFFER_BYTES_DEF = 32;

    // Most data writes one line may produce
    localparam int MAX_WRITES = 24;
    localparam int WR_W       = 5;
    // Width used for line length and byte-count arithmetic
    localparam int CALC_W     = 9;

    // Character codes
    localparam logic [7:0] CHAR_S    = 8'h53;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_LA   = 8'h61;
    localparam logic [7:0] CHAR_LZ   = 8'h7A;
    localparam logic [7:0] CASE_OFS  = 8'h20;
    localparam logic [7:0] ALPHA_OFS = 8'h07;
    localparam logic [7:0] SUM_OK    = 8'hFF;

    // Record type digits
    localparam logic [7:0] REC_S1 = 8'd1;
    localparam logic [7:0] REC_S2 = 8'd2;
    localparam logic [7:0] REC_S3 = 8'd3;
    localparam logic [7:0] REC_S7 = 8'd7;
    localparam logic [7:0] REC_S8 = 8'd8;
    localparam logic [7:0] REC_S9 = 8'd9;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_ACK   = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECV,
        ST_PREP,
        ST_WRITE,
        ST_LAST
    } state_t;

    typedef struct packed {
        logic clear_line;
        logic take_char;
        logic prep;
        logic load_write;
        logic load_final;
        logic len_err;
    } srl_cmd_t;

    typedef struct packed {
        logic is_start;
        logic is_eol;
        logic over_limit;
        logic line_bad;
        logic data_rec;
        logic writes_done;
    } srl_status_t;

endpackage

`default_nettype wire

// File: rtl/srl_datapath.sv
// ----------------------------------------------------------------------------
// srl_datapath : line buffer and result formation
// Decodes hex pairs, keeps the running byte sum, count byte and address,
// stores the decoded bytes in the line buffer and forms the result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srl_datapath #(
    parameter int LINE_LIMIT   = srl_pkg::LINE_LIMIT_DEF,
    parameter int BUFFER_BYTES = srl_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         rx_char,
    input  wire srl_pkg::srl_cmd_t  cmd,
    output srl_pkg::srl_status_t    status,
    output logic [1:0]              kind,
    output logic [31:0]             target_address,
    output logic [7:0]              write_byte,
    output logic                    start_valid,
    output logic                    last_of_line
);

    localparam int CW = $clog2(LINE_LIMIT + 1);
    localparam int AW = $clog2(BUFFER_BYTES);
    localparam int W  = srl_pkg::CALC_W;

    // Hex digit value, lower case folded to upper, 8-bit wrap
    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] u;
        logic [7:0] v;
        u = (c >= srl_pkg::CHAR_LA && c <= srl_pkg::CHAR_LZ) ? c - srl_pkg::CASE_OFS : c;
        v = u - srl_pkg::CHAR_0;
        if (v > 8'd9)
            v = v - srl_pkg::ALPHA_OFS;
        return v;
    endfunction

    // Address bytes by record type
    function automatic logic [2:0] addr_bytes(input logic [7:0] rk);
        logic [2:0] ab;
        if (rk == srl_pkg::REC_S2 || rk == srl_pkg::REC_S8)
            ab = 3'd3;
        else if (rk == srl_pkg::REC_S3 || rk == srl_pkg::REC_S7)
            ab = 3'd4;
        else
            ab = 3'd2;
        return ab;
    endfunction

    logic [CW-1:0]              count_reg;
    logic [7:0]                 rec_kind_reg;
    logic [7:0]                 high_reg;
    logic [7:0]                 sum_reg;
    logic [7:0]                 cnt_byte_reg;
    logic [31:0]                addr_reg;
    logic                       fail_reg;
    logic                       start_reg;
    logic [srl_pkg::WR_W-1:0]   n_reg;
    logic [srl_pkg::WR_W-1:0]   emit_reg;
    logic [7:0]                 rd_data_reg;
    logic [7:0]                 line_mem [BUFFER_BYTES];

    logic [1:0]                 kind_reg;
    logic [31:0]                taddr_reg;
    logic [7:0]                 wbyte_reg;
    logic                       sv_reg;
    logic                       last_reg;

    logic [CW-1:0]              count_inc;
    logic [CW-1:0]              pos;
    logic [W-1:0]               idx_w;
    logic [7:0]                 byte_val;
    logic                       pair_done;
    logic                       mem_we;
    logic [2:0]                 ab;
    logic [W-1:0]               ab_w;
    logic [W-1:0]               nbytes;
    logic [W-1:0]               present;
    logic [W-1:0]               declared;
    logic [W-1:0]               cb_w;
    logic [W-1:0]               n_now;
    logic                       data_rec;
    logic                       start_rec;
    logic                       line_bad;
    logic [srl_pkg::WR_W-1:0]   emit_inc;
    logic [W-1:0]               rd_idx_w;
    logic                       rd_en;

    // Character decode
    assign count_inc = count_reg + CW'(1);
    assign pos       = count_inc - CW'(2);
    assign idx_w     = W'(pos >> 1);
    assign byte_val  = {high_reg[3:0], 4'b0000} | hex_value(rx_char);
    assign pair_done = cmd.take_char && !status.over_limit
                       && (count_inc >= CW'(2)) && pos[0];
    assign mem_we    = pair_done && (idx_w < W'(BUFFER_BYTES));

    // Line checks, evaluated at line end
    assign ab        = addr_bytes(rec_kind_reg);
    assign ab_w      = W'(ab);
    assign nbytes    = (W'(count_reg) - W'(1)) >> 1;
    assign cb_w      = W'(cnt_byte_reg);
    assign present   = nbytes - ab_w - W'(2);
    assign declared  = (cb_w > ab_w + W'(1)) ? cb_w - ab_w - W'(1) : '0;
    assign n_now     = (declared < present) ? declared : present;
    assign data_rec  = rec_kind_reg >= srl_pkg::REC_S1 && rec_kind_reg <= srl_pkg::REC_S3;
    assign start_rec = rec_kind_reg >= srl_pkg::REC_S7 && rec_kind_reg <= srl_pkg::REC_S9;
    assign line_bad  = !count_reg[0]
                       || (nbytes > W'(BUFFER_BYTES))
                       || (sum_reg != srl_pkg::SUM_OK)
                       || (nbytes < ab_w + W'(2))
                       || (data_rec && n_now > W'(srl_pkg::MAX_WRITES));

    // Buffer read sequencing: first data byte at line end, next one per write
    assign emit_inc  = emit_reg + srl_pkg::WR_W'(1);
    assign rd_idx_w  = cmd.prep ? ab_w + W'(1) : ab_w + W'(1) + W'(emit_inc);
    assign rd_en     = (cmd.prep || (cmd.load_write && emit_inc < n_reg))
                       && (rd_idx_w < W'(BUFFER_BYTES));

    // Status to controller
    assign status.is_start    = rx_char == srl_pkg::CHAR_S;
    assign status.is_eol      = rx_char == srl_pkg::CHAR_CR || rx_char == srl_pkg::CHAR_LF;
    assign status.over_limit  = count_inc >= CW'(LINE_LIMIT);
    assign status.line_bad    = line_bad;
    assign status.data_rec    = data_rec;
    assign status.writes_done = emit_reg == n_reg;

    // Line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            rec_kind_reg <= '0;
            high_reg     <= '0;
            sum_reg      <= '0;
            cnt_byte_reg <= '0;
            addr_reg     <= '0;
            fail_reg     <= 1'b0;
            start_reg    <= 1'b0;
            n_reg        <= '0;
            emit_reg     <= '0;
        end
        else
        begin
            if (cmd.clear_line)
            begin
                count_reg    <= '0;
                rec_kind_reg <= '0;
                high_reg     <= '0;
                sum_reg      <= '0;
                addr_reg     <= '0;
            end
            else if (cmd.take_char)
            begin
                count_reg <= count_inc;
                if (!status.over_limit)
                begin
                    if (count_inc == CW'(1))
                        rec_kind_reg <= rx_char - srl_pkg::CHAR_0;
                    else if (!pos[0])
                        high_reg <= hex_value(rx_char);
                    else
                        sum_reg <= sum_reg + byte_val;
                end
            end
            // count byte and address bytes are held aside
            if (pair_done && idx_w == '0)
                cnt_byte_reg <= byte_val;
            if (pair_done && idx_w >= W'(1) && idx_w <= ab_w)
                addr_reg <= {addr_reg[23:0], byte_val};
            // line end outcome
            if (cmd.prep)
            begin
                fail_reg  <= line_bad;
                start_reg <= start_rec;
                n_reg     <= n_now[srl_pkg::WR_W-1:0];
                emit_reg  <= '0;
            end
            else if (cmd.len_err)
            begin
                fail_reg  <= 1'b1;
                start_reg <= 1'b0;
            end
            if (cmd.load_write)
                emit_reg <= emit_inc;
        end
    end

    // Line buffer
    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[idx_w[AW-1:0]] <= byte_val;
        if (rd_en)
            rd_data_reg <= line_mem[rd_idx_w[AW-1:0]];
    end

    // Result word
    always_ff @(posedge clk)
    begin
        if (cmd.load_write)
        begin
            kind_reg  <= srl_pkg::KIND_WRITE;
            taddr_reg <= addr_reg + 32'(emit_reg);
            wbyte_reg <= rd_data_reg;
            sv_reg    <= 1'b0;
            last_reg  <= 1'b0;
        end
        else if (cmd.load_final)
        begin
            kind_reg  <= fail_reg ? srl_pkg::KIND_ERROR : srl_pkg::KIND_ACK;
            taddr_reg <= (!fail_reg && start_reg) ? addr_reg : '0;
            wbyte_reg <= '0;
            sv_reg    <= !fail_reg && start_reg;
            last_reg  <= 1'b1;
        end
    end

    assign kind           = kind_reg;
    assign target_address = taddr_reg;
    assign write_byte     = wbyte_reg;
    assign start_valid    = sv_reg;
    assign last_of_line   = last_reg;

endmodule

`default_nettype wire

// File: rtl/srl_ctrl.sv
// ----------------------------------------------------------------------------
// srl_ctrl : line loader sequencer
// Tracks the line phase, steps the write burst after a line end and owns
// the output word valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module srl_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire srl_pkg::srl_status_t  status,
    output srl_pkg::srl_cmd_t          cmd
);

    srl_pkg::state_t state_reg;
    srl_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            slot_free;
    logic            in_take;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = state_reg == srl_pkg::ST_IDLE || state_reg == srl_pkg::ST_RECV;
    assign in_take   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srl_pkg::ST_IDLE:
                if (in_take && status.is_start)
                    state_next = srl_pkg::ST_RECV;
            srl_pkg::ST_RECV:
                if (in_take)
                begin
                    if (status.is_eol)
                        state_next = srl_pkg::ST_PREP;
                    else if (status.over_limit)
                        state_next = srl_pkg::ST_LAST;
                end
            srl_pkg::ST_PREP:
                state_next = (status.line_bad || !status.data_rec)
                             ? srl_pkg::ST_LAST : srl_pkg::ST_WRITE;
            srl_pkg::ST_WRITE:
                if (status.writes_done)
                    state_next = srl_pkg::ST_LAST;
            srl_pkg::ST_LAST:
                if (slot_free)
                    state_next = srl_pkg::ST_IDLE;
            default:
                state_next = srl_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            srl_pkg::ST_IDLE:
                cmd.clear_line = in_take && status.is_start;
            srl_pkg::ST_RECV:
            begin
                cmd.take_char = in_take && !status.is_eol;
                cmd.len_err   = in_take && !status.is_eol && status.over_limit;
            end
            srl_pkg::ST_PREP:
                cmd.prep = 1'b1;
            srl_pkg::ST_WRITE:
                cmd.load_write = !status.writes_done && slot_free;
            srl_pkg::ST_LAST:
                cmd.load_final = slot_free;
            default:
                cmd = '0;
        endcase
    end

    // Output word valid
    always_comb
    begin
        if (cmd.load_write || cmd.load_final)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srl_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    // a pending word is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_write || cmd.load_final) |-> (!out_valid_reg || out_ready))
        else $error("srl_ctrl: output word overwritten");

    // no write once the burst count is reached
    a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_write |-> !status.writes_done)
        else $error("srl_ctrl: write beyond burst count");

    // a line end stops input until the line is answered
    a_eol_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == srl_pkg::ST_RECV && in_take && status.is_eol) |=> !in_ready)
        else $error("srl_ctrl: input taken after line end");

    // final word of a line is followed by a return to idle
    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_final |=> (state_reg == srl_pkg::ST_IDLE && out_valid_reg))
        else $error("srl_ctrl: line end not closed");
`endif

endmodule

`default_nettype wire

// File: rtl/srecord_line_loader_top.sv
// ----------------------------------------------------------------------------
// srecord_line_loader_top : S-record line loader
// Turns a received character stream into memory byte writes and line acks.
// ----------------------------------------------------------------------------
// One character word is taken per cycle while a line is being received; the
// output register lets a new line start while the last answer is unread.
// At a line end the block stops input for the checks, then for a data
// record through one step per write, a step to see the burst finish and
// the ack, or through the checks and the ack alone for any other record or a
// failed check. A line cut off at the length limit stops input only for the
// step that gives the error. Any stall on the output side lengthens each
// pause. The write burst rate is set by the single read port of the line
// buffer: one byte per cycle while the output side takes every word. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module srecord_line_loader_top #(
    parameter int LINE_LIMIT   = srl_pkg::LINE_LIMIT_DEF,
    parameter int BUFFER_BYTES = srl_pkg::BUFFER_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_char,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [31:0]      target_address,
    output logic [7:0]       write_byte,
    output logic             start_valid,
    output logic             last_of_line
);

    srl_pkg::srl_cmd_t    cmd;
    srl_pkg::srl_status_t status;

    // Sequencer
    srl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Buffer and result word
    srl_datapath #(
        .LINE_LIMIT   (LINE_LIMIT),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_char        (rx_char),
        .cmd            (cmd),
        .status         (status),
        .kind           (kind),
        .target_address (target_address),
        .write_byte     (write_byte),
        .start_valid    (start_valid),
        .last_of_line   (last_of_line)
    );

endmodule

`default_nettype wire
